>>> sv/d2f34_pkg.sv
// Package for the double to float34 round-to-odd converter.
// Constants and field types; no dependencies.
package d2f34_pkg;
	localparam int unsigned DataWidth = 64;
	localparam int unsigned CodeWidth = 34;
	localparam logic [63:0] ExpMask    = 64'h7FF0000000000000;
	localparam logic [63:0] MaxFinBits = 64'h47EFFFFFF8000000;
	localparam logic [63:0] MaxM1Bits  = 64'h47EFFFFFF0000000;
	localparam logic [63:0] TinyBits   = 64'h3690000000000000;
	localparam logic [63:0] MinSubBits = 64'h3680000000000000;

	typedef struct packed {
		logic [63:0] rounded_bits;
		logic [33:0] packed_code;
		logic        nan_flag;
	} result_t;
endpackage

>>> sv/d2f34_if.sv
// Valid/ready channel interface carrying a payload of type T.
// No dependencies.
interface d2f34_if #(parameter type T = logic [63:0]) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/double_to_float34_round_to_odd.sv
// Converts binary64 patterns to float34 with round-to-odd, one item per clock while not stalled.
// Data passes an input register, then the conversion logic feeds the
// output register. Throughput is one item every cycle; ready drops only while
// the output register holds an untaken result and the input register is full.
// Depends on d2f34_pkg, d2f34_if and d2f34_round.
module double_to_float34_round_to_odd import d2f34_pkg::*; (
	input logic clk,
	input logic arst_n,
	d2f34_if.sink   in_ch,
	d2f34_if.source out_ch
);
	logic [63:0] data_s1;
	logic        valid_s1;
	result_t     res;
	result_t     res_s2;
	logic        valid_s2;
	logic        adv_s2;

	assign adv_s2       = !valid_s2 || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || adv_s2;
	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	d2f34_round u_round (.value_bits(data_s1), .res(res));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) data_s1 <= in_ch.data;
		if (adv_s2 && valid_s1) res_s2 <= res;
	end
endmodule

>>> sv/d2f34_round.sv
// Combinational round-to-odd of a binary64 value into float34, with packing.
// Depends on d2f34_pkg.
module d2f34_round import d2f34_pkg::*; (
	input  logic [63:0] value_bits,
	output result_t     res
);
	logic [62:0] mag;
	logic [10:0] bexp;
	logic [4:0]  kept;
	logic [5:0]  cut;
	logic [63:0] lowmask;
	logic [63:0] r;
	logic        nan;
	logic [9:0]  ex;
	logic [25:0] mant;
	logic [33:0] code;

	assign mag  = value_bits[62:0];
	assign bexp = value_bits[62:52];

	// kept bits = bexp - 872, clamped to 1..25
	always_comb begin
		if (bexp <= 11'd873) kept = 5'd1;
		else if (bexp >= 11'd897) kept = 5'd25;
		else kept = 5'(bexp - 11'd872);
		cut     = 6'd52 - {1'b0, kept};
		lowmask = (64'd1 << cut) - 64'd1;
	end

	// rounding and special cases
	always_comb begin
		nan = 1'b0;
		if ({1'b0, mag} > ExpMask) begin
			r = value_bits;
			nan = 1'b1;
		end else if (mag == 63'd0) begin
			r = '0;
		end else if ({1'b0, mag} == ExpMask) begin
			r = value_bits;
		end else if ({1'b0, mag} < TinyBits) begin
			r = {value_bits[63], MinSubBits[62:0]};
		end else if ({1'b0, mag} > MaxM1Bits) begin
			r = {value_bits[63], MaxFinBits[62:0]};
		end else begin
			r = value_bits & ~lowmask;
			if ((value_bits & lowmask) != 64'd0) r = r | (64'd1 << cut);
		end
	end

	// pack into 34 bits: zero, infinity, subnormal or normal in target; a NaN packs as 0
	always_comb begin
		ex   = 10'(r[62:52]) - 10'd896;
		mant = {1'b0, r[51:27]};
		code = {r[63], 33'd0};
		if (r[62:0] == 63'd0) begin
			code = '0;
		end else if ({1'b0, r[62:0]} == ExpMask) begin
			code = {r[63], 8'hFF, 25'd0};
		end else if ($signed(ex) < 10'sd1) begin
			mant = {1'b1, r[51:27]} >> (10'd1 - ex);
			code = {r[63], 8'd0, mant[24:0]};
		end else begin
			code = {r[63], ex[7:0], mant[24:0]};
		end
		res.rounded_bits = r;
		res.packed_code  = nan ? 34'd0 : code;
		res.nan_flag     = nan;
	end
endmodule
